/* hw/rtl/upst_pkg.sv */
// Shared types and constants for the unordered pair set table.
package upst_pkg;

	// Table geometry
	localparam int MAX_PAIRS = 256;
	localparam int IDX_W     = $clog2(MAX_PAIRS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int ATOM_BITS = 16;

	// Only the low ATOM_BITS of an atom index take part
	localparam logic [15:0] ATOM_MASK = 16'((64'd1 << ATOM_BITS) - 64'd1);

	// Command codes
	localparam logic [1:0] CMD_QUERY  = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] first_atom;
		logic [15:0] second_atom;
		logic [7:0]  entry_index;
	} upst_req_t;

	typedef struct packed {
		logic        was_present;
		logic [7:0]  match_position;
		logic [8:0]  pair_count;
		logic [15:0] read_first;
		logic [15:0] read_second;
		logic [1:0]  status;
	} upst_rsp_t;

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] second;
	} upst_pair_t;

endpackage

/* hw/rtl/unordered_pair_set_table_core.sv */
// Unordered pair set table: sequencer, pair memory and result register.
//
// Usage: one request goes in on the cmd channel (cmd_valid, cmd_stall, cmd_data)
// and exactly one result comes back on the res channel (res_valid, res_stall,
// res_data). cmd_stall stays high from the accepting edge until the sequencer
// returns to idle, so only one request is in work at a time.
// Every request but a read walks the stored pairs from position 0, one memory
// read per cycle through a one-stage compare pipeline, and stops at the first
// match. A remove that hits also moves each later entry down one place, one
// entry per cycle through the same memory port. A read goes through S_RDWAIT
// to S_DONE, or straight to S_DONE when the index is out of range. The worst
// case is a remove that hits in a full table, set by the single memory port.
// A new request is taken the cycle after the result is loaded.
// Reset clears the pair count and the sequencer; the memory is not cleared,
// since only entries below the count are ever used.
// The result sits in an output register. The next request is taken while it
// waits; if res_stall holds, the sequencer waits in its last state until the
// register is free.
module unordered_pair_set_table_core
	import upst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  upst_req_t cmd_data,
	output logic      res_valid,
	input  logic      res_stall,
	output upst_rsp_t res_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_ACT,
		S_SHIFT,
		S_RDWAIT,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [1:0]          cmd_q;
	logic [15:0]         x_q;
	logic [15:0]         y_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    scan_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    pos_s1;
	logic                found_q;
	logic [IDX_W-1:0]    pos_q;
	logic [1:0]          status_q;
	upst_pair_t          rdata_q;
	logic                res_valid_q;
	upst_rsp_t           res_q;

	upst_pair_t          mem [MAX_PAIRS];
	upst_pair_t          mem_q;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	upst_pair_t          mem_wd;
	logic [IDX_W-1:0]    mem_ra;

	logic                accept;
	logic                hit;
	logic                out_free;
	logic [15:0]         in_x;
	logic [15:0]         in_y;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;
	assign out_free  = !res_valid_q || !res_stall;
	assign in_x      = cmd_data.first_atom & ATOM_MASK;
	assign in_y      = cmd_data.second_atom & ATOM_MASK;

	// Pair compare on the registered memory word, either orientation
	assign hit = vld_s1 &&
		((mem_q.first == x_q && mem_q.second == y_q) ||
		 (mem_q.first == y_q && mem_q.second == x_q));

	// Memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_ra = '0;
		case (state_q)
			S_IDLE: begin
				mem_ra = IDX_W'(cmd_data.entry_index);
			end
			S_SEARCH: begin
				mem_ra = scan_q[IDX_W-1:0];
			end
			S_ACT: begin
				mem_we = (cmd_q == CMD_ADD) && !found_q && (count_q < CNT_W'(MAX_PAIRS));
				mem_wa = count_q[IDX_W-1:0];
				mem_wd = '{first: x_q, second: y_q};
			end
			S_SHIFT: begin
				mem_ra = scan_q[IDX_W-1:0];
				mem_we = vld_s1;
				mem_wa = pos_s1;
				mem_wd = mem_q;
			end
			default: begin
				mem_ra = '0;
			end
		endcase
	end

	// Pair memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_q <= mem[mem_ra];
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
			cmd_q       <= CMD_QUERY;
			x_q         <= '0;
			y_q         <= '0;
			pos_s1      <= '0;
			found_q     <= 1'b0;
			pos_q       <= '0;
			status_q    <= ST_OK;
			rdata_q     <= '0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd_data.command;
						x_q      <= in_x;
						y_q      <= in_y;
						found_q  <= 1'b0;
						pos_q    <= '0;
						status_q <= ST_OK;
						rdata_q  <= '0;
						scan_q   <= '0;
						vld_s1   <= 1'b0;
						if (cmd_data.command == CMD_READ) begin
							if (CNT_W'(cmd_data.entry_index) < count_q) begin
								state_q <= S_RDWAIT;
							end else begin
								status_q <= ST_RANGE;
								state_q  <= S_DONE;
							end
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (hit) begin
						found_q <= 1'b1;
						pos_q   <= pos_s1;
						vld_s1  <= 1'b0;
						state_q <= S_ACT;
					end else if (!vld_s1 && scan_q >= count_q) begin
						state_q <= S_ACT;
					end else if (scan_q < count_q) begin
						vld_s1 <= 1'b1;
						pos_s1 <= scan_q[IDX_W-1:0];
						scan_q <= scan_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
				end
				S_ACT: begin
					if (cmd_q == CMD_REMOVE && found_q) begin
						// Next entry to move down sits one past the match
						scan_q  <= CNT_W'(pos_q) + 1'b1;
						vld_s1  <= 1'b0;
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_DONE;
						if (cmd_q == CMD_ADD && !found_q) begin
							if (count_q >= CNT_W'(MAX_PAIRS)) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
					end
				end
				S_SHIFT: begin
					if (!vld_s1 && scan_q >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end else if (scan_q < count_q) begin
						vld_s1 <= 1'b1;
						pos_s1 <= IDX_W'(scan_q - 1'b1);
						scan_q <= scan_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
				end
				S_RDWAIT: begin
					rdata_q <= mem_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						res_q.was_present    <= found_q;
						res_q.match_position <= 8'(pos_q);
						res_q.pair_count     <= 9'(count_q);
						res_q.read_first     <= rdata_q.first;
						res_q.read_second    <= rdata_q.second;
						res_q.status         <= status_q;
						res_valid_q          <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
